[design/lr4_pkg.sv]
package lr4_pkg;

	localparam int COEF_BITS      = 32;
	localparam int STATE_BITS     = 48;
	localparam int GUARD_BITS     = 8;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_B0      = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_B0     = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK_A1 = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK_A2 = 2'd3;

	localparam logic signed [COEF_BITS-1:0] LOW_B0_RESET      = 32'sd314491699;
	localparam logic signed [COEF_BITS-1:0] HIGH_B0_RESET     = 32'sd314491699;
	localparam logic signed [COEF_BITS-1:0] FEEDBACK_A1_RESET = 32'sd0;
	localparam logic signed [COEF_BITS-1:0] FEEDBACK_A2_RESET = 32'sd184225110;

	typedef enum logic [1:0] {
		OP_Y  = 2'd0,
		OP_Z1 = 2'd1,
		OP_Z2 = 2'd2
	} alu_op_t;

	typedef struct packed {
		logic signed [STATE_BITS-1:0] z1;
		logic signed [STATE_BITS-1:0] z2;
	} delay_t;

endpackage

[design/lr4_mul.sv]
module lr4_mul #(
	parameter int A_BITS = 32,
	parameter int B_BITS = 24
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [A_BITS-1:0]         a,
	input  logic signed [B_BITS-1:0]         b,
	output logic signed [A_BITS+B_BITS-1:0]  prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

[design/lr4_alu.sv]
module lr4_alu #(
	parameter int SAMPLE_BITS = 24,
	parameter int PW          = 56,
	parameter int SH          = 22,
	parameter int AW          = 50
) (
	input  lr4_pkg::alu_op_t                        op,
	input  logic signed [AW-1:0]                    t_in,
	input  logic signed [lr4_pkg::STATE_BITS-1:0]   z_in,
	input  logic signed [PW-1:0]                    prod,
	output logic signed [SAMPLE_BITS-1:0]           y,
	output logic signed [lr4_pkg::STATE_BITS-1:0]   z
);

	localparam int SB = lr4_pkg::STATE_BITS;

	localparam logic signed [AW-1:0] Y_HI = {{(AW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [AW-1:0] Y_LO = ~Y_HI;
	localparam logic signed [AW-1:0] Z_HI = {{(AW-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [AW-1:0] Z_LO = ~Z_HI;
	localparam logic signed [AW-1:0] HALF = AW'(1) <<< (lr4_pkg::GUARD_BITS - 1);

	logic signed [AW-1:0] prod_sh;
	logic signed [AW-1:0] opb;
	logic signed [AW-1:0] opc;
	logic signed [AW-1:0] sum;
	logic signed [AW-1:0] rnd;

	always_comb begin
		prod_sh = AW'(prod >>> SH);
		case (op)
			lr4_pkg::OP_Y: begin
				opb = AW'(z_in);
				opc = HALF;
			end
			lr4_pkg::OP_Z1: begin
				opb = -prod_sh;
				opc = AW'(z_in);
			end
			lr4_pkg::OP_Z2: begin
				opb = -prod_sh;
				opc = '0;
			end
			default: begin
				opb = '0;
				opc = '0;
			end
		endcase
		sum = t_in + opb + opc;
		rnd = sum >>> lr4_pkg::GUARD_BITS;
		if (rnd > Y_HI) begin
			y = Y_HI[SAMPLE_BITS-1:0];
		end else if (rnd < Y_LO) begin
			y = Y_LO[SAMPLE_BITS-1:0];
		end else begin
			y = rnd[SAMPLE_BITS-1:0];
		end
		if (sum > Z_HI) begin
			z = Z_HI[SB-1:0];
		end else if (sum < Z_LO) begin
			z = Z_LO[SB-1:0];
		end else begin
			z = sum[SB-1:0];
		end
	end

endmodule

[design/lr4_crossover_split.sv]
// Fourth-order crossover, one shared multiplier and one shared add/saturate unit.
// Each biquad stage steps through S_MULP, S_ACC, S_MULA1, S_Z1 and S_Z2. A new sample
// is taken only in S_IDLE, after every stage of both bands has used the single multiplier.
// out_valid is registered and rises once S_DONE finds the output slot free.
// Reset clears the delay state, loads the default coefficients and drops out_valid.
module lr4_crossover_split #(
	parameter int SAMPLE_BITS     = 24,
	parameter int COEF_FRAC_BITS  = 30,
	parameter int STAGES_PER_BAND = 2
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [lr4_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
	input  logic [lr4_pkg::COEF_BITS-1:0]           cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [SAMPLE_BITS-1:0]           sample_in,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [SAMPLE_BITS-1:0]           low_sample,
	output logic signed [SAMPLE_BITS-1:0]           high_sample
);

	localparam int CB    = lr4_pkg::COEF_BITS;
	localparam int ZB    = lr4_pkg::STATE_BITS;
	localparam int PW    = CB + SAMPLE_BITS;
	localparam int SH    = COEF_FRAC_BITS - lr4_pkg::GUARD_BITS;
	localparam int AW    = (((PW - SH + 2) > ZB) ? (PW - SH + 2) : ZB) + 2;
	localparam int DEPTH = 2 * STAGES_PER_BAND;
	localparam int SW    = $clog2(DEPTH);

	localparam logic [SW-1:0] STG_FIRST_HIGH = SW'(STAGES_PER_BAND);
	localparam logic [SW-1:0] STG_LAST_LOW   = SW'(STAGES_PER_BAND - 1);
	localparam logic [SW-1:0] STG_LAST       = SW'(DEPTH - 1);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_MULP  = 7'b0000010,
		S_ACC   = 7'b0000100,
		S_MULA1 = 7'b0001000,
		S_Z1    = 7'b0010000,
		S_Z2    = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [SW-1:0] stg_q;

	logic signed [CB-1:0] low_b0_q;
	logic signed [CB-1:0] high_b0_q;
	logic signed [CB-1:0] a1_q;
	logic signed [CB-1:0] a2_q;

	lr4_pkg::delay_t ring_q [DEPTH];

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [SAMPLE_BITS-1:0] y_q;
	logic signed [SAMPLE_BITS-1:0] low_res_q;
	logic signed [AW-1:0]          t0_q;
	logic signed [AW-1:0]          t1_q;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] low_q;
	logic signed [SAMPLE_BITS-1:0] high_q;

	logic                          high_band;
	logic                          first_stage;
	logic                          mul_en;
	logic signed [CB-1:0]          mul_a;
	logic signed [SAMPLE_BITS-1:0] mul_b;
	logic signed [PW-1:0]          prod_q;
	logic signed [AW-1:0]          t0;
	logic signed [AW-1:0]          t1;
	lr4_pkg::alu_op_t              alu_op;
	logic signed [AW-1:0]          alu_t;
	logic signed [ZB-1:0]          alu_z_in;
	logic signed [SAMPLE_BITS-1:0] alu_y;
	logic signed [ZB-1:0]          alu_z;
	logic                          accept;
	logic                          slot_free;

	assign high_band   = (stg_q >= STG_FIRST_HIGH);
	assign first_stage = (stg_q == '0) || (stg_q == STG_FIRST_HIGH);
	assign accept      = in_valid && in_ready;
	assign slot_free   = !out_valid_q || out_ready;
	assign in_ready    = (state_q == S_IDLE);

	assign t0 = AW'(prod_q >>> SH);
	assign t1 = AW'(prod_q >>> (SH - 1));

	always_comb begin
		mul_en = 1'b0;
		mul_a  = a1_q;
		mul_b  = y_q;
		case (state_q)
			S_MULP: begin
				mul_en = 1'b1;
				mul_a  = high_band ? high_b0_q : low_b0_q;
				mul_b  = first_stage ? sample_q : y_q;
			end
			S_MULA1: begin
				mul_en = 1'b1;
			end
			S_Z1: begin
				mul_en = 1'b1;
				mul_a  = a2_q;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	lr4_mul #(
		.A_BITS(CB),
		.B_BITS(SAMPLE_BITS)
	) u_mul (
		.clk   (clk),
		.en    (mul_en),
		.a     (mul_a),
		.b     (mul_b),
		.prod_q(prod_q)
	);

	always_comb begin
		case (state_q)
			S_ACC: begin
				alu_op   = lr4_pkg::OP_Y;
				alu_t    = t0;
				alu_z_in = ring_q[0].z1;
			end
			S_Z1: begin
				alu_op   = lr4_pkg::OP_Z1;
				alu_t    = t1_q;
				alu_z_in = ring_q[0].z2;
			end
			default: begin
				alu_op   = lr4_pkg::OP_Z2;
				alu_t    = t0_q;
				alu_z_in = ring_q[0].z2;
			end
		endcase
	end

	lr4_alu #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.PW         (PW),
		.SH         (SH),
		.AW         (AW)
	) u_alu (
		.op  (alu_op),
		.t_in(alu_t),
		.z_in(alu_z_in),
		.prod(prod_q),
		.y   (alu_y),
		.z   (alu_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_b0_q  <= lr4_pkg::LOW_B0_RESET;
			high_b0_q <= lr4_pkg::HIGH_B0_RESET;
			a1_q      <= lr4_pkg::FEEDBACK_A1_RESET;
			a2_q      <= lr4_pkg::FEEDBACK_A2_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lr4_pkg::REG_LOW_B0:      low_b0_q  <= cfg_data;
				lr4_pkg::REG_HIGH_B0:     high_b0_q <= cfg_data;
				lr4_pkg::REG_FEEDBACK_A1: a1_q      <= cfg_data;
				lr4_pkg::REG_FEEDBACK_A2: a2_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stg_q   <= '0;
			for (int i = 0; i < DEPTH; i++) begin
				ring_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						stg_q   <= '0;
						state_q <= S_MULP;
					end
				end
				S_MULP:  state_q <= S_ACC;
				S_ACC:   state_q <= S_MULA1;
				S_MULA1: state_q <= S_Z1;
				S_Z1: begin
					ring_q[0].z1 <= alu_z;
					state_q      <= S_Z2;
				end
				S_Z2: begin
					// rotate so the next stage sits at the head
					for (int i = 0; i < DEPTH - 1; i++) begin
						ring_q[i] <= ring_q[i+1];
					end
					ring_q[DEPTH-1] <= '{z1: ring_q[0].z1, z2: alu_z};
					if (stg_q == STG_LAST) begin
						state_q <= S_DONE;
					end else begin
						stg_q   <= stg_q + SW'(1);
						state_q <= S_MULP;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample_in;
		end
		if (state_q == S_ACC) begin
			y_q  <= alu_y;
			t0_q <= t0;
			t1_q <= high_band ? -t1 : t1;
		end
		if (state_q == S_Z2 && stg_q == STG_LAST_LOW) begin
			low_res_q <= y_q;
		end
		if (state_q == S_DONE && slot_free) begin
			low_q  <= low_res_q;
			high_q <= y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign low_sample  = low_q;
	assign high_sample = high_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_MULP) && (stg_q == '0))
		else $error("accepted request did not start at the first stage");

	a_last_stage_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_Z2) && (stg_q == STG_LAST) |=> (state_q == S_DONE))
		else $error("last stage did not finish the request");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside completion");

	a_stage_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (stg_q <= STG_LAST))
		else $error("stage counter out of range");

endmodule

[test/lr4_crossover_split_check.sv]
`timescale 1ns / 100ps

module lr4_crossover_split_check #(
	parameter int SAMPLE_BITS     = 24,
	parameter int COEF_FRAC_BITS  = 30,
	parameter int STAGES_PER_BAND = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lr4_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [lr4_pkg::COEF_BITS-1:0]      cfg_data,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic signed [SAMPLE_BITS-1:0]      sample_in,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic signed [SAMPLE_BITS-1:0]      low_sample,
	input  logic signed [SAMPLE_BITS-1:0]      high_sample,
	output int                                 fails,
	output int                                 pending
);

	localparam int PROD_SHIFT  = COEF_FRAC_BITS - lr4_pkg::GUARD_BITS;
	localparam int DELAY_DEPTH = 2 * STAGES_PER_BAND;
	localparam int ZB          = lr4_pkg::STATE_BITS;
	localparam int LOW_BAND    = 0;
	localparam int HIGH_BAND   = 1;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] low;
		logic signed [SAMPLE_BITS-1:0] high;
	} band_pair_t;

	logic signed [lr4_pkg::COEF_BITS-1:0]  low_b0;
	logic signed [lr4_pkg::COEF_BITS-1:0]  high_b0;
	logic signed [lr4_pkg::COEF_BITS-1:0]  feedback_a1;
	logic signed [lr4_pkg::COEF_BITS-1:0]  feedback_a2;
	logic signed [lr4_pkg::STATE_BITS-1:0] band_z [2][DELAY_DEPTH];
	band_pair_t                            expected_splits [$];

	function automatic longint clamp(input longint v, input int w);
		longint hi;
		hi = (longint'(1) << (w - 1)) - 1;
		if (v > hi)
			return hi;
		if (v < -hi - 1)
			return -hi - 1;
		return v;
	endfunction

	function automatic longint run_band(input int band, input longint x_in);
		longint x;
		longint b0;
		longint p;
		longint t0;
		longint t1;
		longint acc;
		longint y;
		longint z1;
		longint z2;
		int     s;
		x = x_in;
		b0 = (band == LOW_BAND) ? longint'(low_b0) : longint'(high_b0);
		for (s = 0; s < STAGES_PER_BAND; s++) begin
			z1 = longint'(band_z[band][2*s]);
			z2 = longint'(band_z[band][2*s+1]);
			p = b0 * x;
			t0 = p >>> PROD_SHIFT;
			t1 = p >>> (PROD_SHIFT - 1);
			acc = t0 + z1;
			y = clamp((acc + (longint'(1) << (lr4_pkg::GUARD_BITS - 1))) >>> lr4_pkg::GUARD_BITS,
				SAMPLE_BITS);
			if (band == HIGH_BAND)
				t1 = -t1;
			band_z[band][2*s] = ZB'(clamp(t1 - ((longint'(feedback_a1) * y) >>> PROD_SHIFT) + z2,
				lr4_pkg::STATE_BITS));
			band_z[band][2*s+1] = ZB'(clamp(t0 - ((longint'(feedback_a2) * y) >>> PROD_SHIFT),
				lr4_pkg::STATE_BITS));
			x = y;
		end
		return x;
	endfunction

	function automatic band_pair_t split_sample(input logic signed [SAMPLE_BITS-1:0] x);
		band_pair_t r;
		r.low = SAMPLE_BITS'(run_band(LOW_BAND, longint'(x)));
		r.high = SAMPLE_BITS'(run_band(HIGH_BAND, longint'(x)));
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		band_pair_t want;
		int         b;
		int         i;
		if (!arst_n) begin
			low_b0 = lr4_pkg::LOW_B0_RESET;
			high_b0 = lr4_pkg::HIGH_B0_RESET;
			feedback_a1 = lr4_pkg::FEEDBACK_A1_RESET;
			feedback_a2 = lr4_pkg::FEEDBACK_A2_RESET;
			for (b = 0; b < 2; b++)
				for (i = 0; i < DELAY_DEPTH; i++)
					band_z[b][i] = '0;
			expected_splits.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_splits.size() == 0) begin
					$display("%0t: result with no request pending: low %0d high %0d",
						$time, low_sample, high_sample);
					fails++;
				end else begin
					want = expected_splits.pop_front();
					if (low_sample !== want.low) begin
						$display("%0t: low_sample expected %0d, got %0d",
							$time, want.low, low_sample);
						fails++;
					end
					if (high_sample !== want.high) begin
						$display("%0t: high_sample expected %0d, got %0d",
							$time, want.high, high_sample);
						fails++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					lr4_pkg::REG_LOW_B0:      low_b0 = cfg_data;
					lr4_pkg::REG_HIGH_B0:     high_b0 = cfg_data;
					lr4_pkg::REG_FEEDBACK_A1: feedback_a1 = cfg_data;
					lr4_pkg::REG_FEEDBACK_A2: feedback_a2 = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_splits.push_back(split_sample(sample_in));
			pending = expected_splits.size();
		end
	end

endmodule

[test/lr4_crossover_split_test.sv]
`timescale 1ns / 100ps

module lr4_crossover_split_test;

	localparam int SAMPLE_BITS   = 24;
	localparam int NUM_PHASES    = 10;
	localparam int PHASE_ITEMS   = 125;
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_MARGIN   = 4;
	localparam int END_CYCLES    = 40;

	localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = 24'sh800000;
	localparam logic [lr4_pkg::COEF_BITS-1:0] COEF_MAX = 32'h7FFFFFFF;
	localparam logic [lr4_pkg::COEF_BITS-1:0] COEF_MIN = 32'h80000000;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               cfg_we;
	logic [lr4_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [lr4_pkg::COEF_BITS-1:0]      cfg_data;
	logic                               in_valid;
	logic                               in_ready;
	logic signed [SAMPLE_BITS-1:0]      sample_in;
	logic                               out_valid;
	logic                               out_ready;
	logic signed [SAMPLE_BITS-1:0]      low_sample;
	logic signed [SAMPLE_BITS-1:0]      high_sample;
	int                                 fails;
	int                                 pending;

	int hold_asked = 0;
	int hold_done = 0;
	int samples_sent = 0;
	int settings = 0;
	int walk = 0;

	always #1 clk = ~clk;

	lr4_crossover_split i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.low_sample (low_sample),
		.high_sample(high_sample)
	);

	lr4_crossover_split_check i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.low_sample (low_sample),
		.high_sample(high_sample),
		.fails      (fails),
		.pending    (pending)
	);

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : receiver
		int seg_mode;
		int seg_len;
		out_ready = 1'b0;
		forever begin
			seg_mode = $urandom_range(0, 3);
			seg_len = $urandom_range(1, 60);
			repeat (seg_len) begin
				@(negedge clk);
				if (hold_asked != hold_done) begin
					out_ready <= 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
					hold_done++;
				end else begin
					case (seg_mode)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom_range(0, 1));
						2: out_ready <= ($urandom_range(0, 3) == 0);
						default: out_ready <= 1'b0;
					endcase
				end
			end
		end
	end

	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
		@(negedge clk);
		in_valid <= 1'b1;
		sample_in <= s;
		do @(posedge clk); while (!in_ready);
		samples_sent++;
	endtask

	task automatic pause(input int n);
		@(negedge clk);
		in_valid <= 1'b0;
		sample_in <= SAMPLE_BITS'($urandom);
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic drain();
		pause(1);
		wait (pending == 0);
		repeat (IDLE_MARGIN) @(negedge clk);
	endtask

	task automatic write_reg(input logic [lr4_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [lr4_pkg::COEF_BITS-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
	endtask

	task automatic write_coefs(input logic [lr4_pkg::COEF_BITS-1:0] low_gain,
			input logic [lr4_pkg::COEF_BITS-1:0] high_gain,
			input logic [lr4_pkg::COEF_BITS-1:0] a1,
			input logic [lr4_pkg::COEF_BITS-1:0] a2);
		write_reg(lr4_pkg::REG_LOW_B0, low_gain);
		write_reg(lr4_pkg::REG_HIGH_B0, high_gain);
		write_reg(lr4_pkg::REG_FEEDBACK_A1, a1);
		write_reg(lr4_pkg::REG_FEEDBACK_A2, a2);
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_data <= $urandom;
		settings++;
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] next_sample();
		int                            kind;
		logic signed [SAMPLE_BITS-1:0] r;
		kind = $urandom_range(0, 9);
		if (kind < 4) begin
			walk = walk + (int'($urandom_range(0, 8191)) - 4096) * 64;
			if (walk > 8388607)
				walk = 8388607;
			if (walk < -8388608)
				walk = -8388608;
			r = SAMPLE_BITS'(walk);
		end else if (kind < 7) begin
			r = SAMPLE_BITS'($urandom);
		end else if (kind == 7) begin
			case ($urandom_range(0, 4))
				0: r = SMP_MAX;
				1: r = SMP_MIN;
				2: r = '0;
				3: r = SAMPLE_BITS'(1);
				default: r = SAMPLE_BITS'(-1);
			endcase
		end else if (kind == 8) begin
			r = SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
		end else begin
			r = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
		end
		return r;
	endfunction

	function automatic logic [lr4_pkg::COEF_BITS-1:0] pick_coef();
		logic [lr4_pkg::COEF_BITS-1:0] c;
		case ($urandom_range(0, 5))
			0: c = $urandom;
			1: c = COEF_MAX;
			2: c = COEF_MIN;
			3: c = '0;
			4: c = int'($urandom_range(0, 1 << 30)) - (1 << 29);
			default: c = (1 << 30) + int'($urandom_range(0, 1 << 24)) - (1 << 23);
		endcase
		return c;
	endfunction

	initial begin : stimulus
		logic signed [SAMPLE_BITS-1:0] corner_samples [12];
		int                            phase;
		int                            phase_sent;
		int                            burst;
		bit                            held;
		bit                            paused;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		sample_in = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		corner_samples = '{'0, SMP_MAX, SMP_MIN, SAMPLE_BITS'(1), SAMPLE_BITS'(-1), SMP_MAX,
			SMP_MAX, SMP_MAX, SMP_MIN, SMP_MIN, SMP_MIN, '0};
		foreach (corner_samples[i])
			send_sample(corner_samples[i]);

		// drive stage outputs past full scale
		drain();
		write_coefs(COEF_MAX, COEF_MAX, '0, '0);
		send_sample(SMP_MAX);
		send_sample(SMP_MIN);
		send_sample(SMP_MAX);
		send_sample(SMP_MAX);
		send_sample(SMP_MIN);
		send_sample(SAMPLE_BITS'(1));

		drain();
		write_coefs(COEF_MIN, COEF_MIN, COEF_MAX, COEF_MIN);
		send_sample(SMP_MAX);
		send_sample(SMP_MAX);
		send_sample(SMP_MIN);
		send_sample(SMP_MIN);
		send_sample('0);
		send_sample(SMP_MAX);

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			drain();
			case (phase)
				0: write_coefs(104857600, 610951000, -1012316784, 357913941);
				1: write_coefs(731000, 1048600000, -2098000000, 1027000000);
				2: write_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
				3: write_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
				4: write_coefs(COEF_MAX, COEF_MIN, '0, COEF_MAX);
				default: write_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef());
			endcase
			phase_sent = 0;
			held = 1'b0;
			paused = 1'b0;
			while (phase_sent < PHASE_ITEMS) begin
				if (!held && phase % 3 == 1 && phase_sent >= 40) begin
					// hold the output side and keep offering so the input backs up
					held = 1'b1;
					hold_asked++;
					repeat (12) send_sample(next_sample());
					phase_sent += 12;
				end else if (!paused && phase == 5 && phase_sent >= 60) begin
					paused = 1'b1;
					drain();
				end else begin
					if ($urandom_range(0, 7) == 0)
						burst = $urandom_range(40, 80);
					else
						burst = $urandom_range(1, 16);
					repeat (burst) send_sample(next_sample());
					phase_sent += burst;
					if ($urandom_range(0, 3) != 0)
						pause($urandom_range(1, 30));
				end
			end
		end

		pause(1);
		wait (pending == 0);
		repeat (END_CYCLES) @(posedge clk);

		$display("Split %0d samples into low and high bands under %0d coefficient settings,",
			samples_sent, settings);
		$display("with saturating gains, unstable feedback and long output back-pressure.");
		if (fails == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
